@@ src/skc_pkg.sv @@
// Shared types and constants for the soft-knee compressor gain computer.
// Depends on nothing; every other file imports it.
`default_nettype none

package skc_pkg;

  localparam int THR_W      = 14;
  localparam int SLOPE_W    = 16;
  localparam int KNEE_W     = 13;
  localparam int COEFF_W    = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam int LOG2_W = 24;  // log2 of level, signed Q.16
  localparam int PDB_W  = 24;  // gain attenuation in dB, Q.16, clamped

  localparam logic signed [THR_W-1:0]   THRESHOLD_RST  = 14'sd0;
  localparam logic [SLOPE_W-1:0]        SLOPE_RST      = 16'd32768;
  localparam logic [KNEE_W-1:0]         KNEE_WIDTH_RST = 13'd1536;
  localparam logic [COEFF_W-1:0]        KNEE_COEFF_RST = 24'd1365;

  localparam logic signed [19:0]  DB_PER_OCT_Q16 = 20'sd394566;
  localparam logic signed [22:0]  OCT_PER_DB_Q24 = 23'sd2786618;
  localparam logic [PDB_W-1:0]    GDB_FLOOR_Q16  = 24'd13107200;

  typedef enum logic [1:0] {
    REGION_BELOW = 2'd0,
    REGION_KNEE  = 2'd1,
    REGION_COMP  = 2'd2
  } skc_region_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_SLOPE      = 2'd1,
    CFG_KNEE_WIDTH = 2'd2,
    CFG_KNEE_COEFF = 2'd3
  } skc_cfg_idx_e;

  typedef struct packed {
    logic signed [THR_W-1:0] threshold;
    logic [SLOPE_W-1:0]      slope;
    logic [KNEE_W-1:0]       knee_width;
    logic [COEFF_W-1:0]      knee_coeff;
  } skc_cfg_t;

  typedef struct packed {
    logic                     valid;
    logic                     zero;
    logic signed [LOG2_W-1:0] lg;
  } skc_log_t;

  typedef struct packed {
    logic              valid;
    skc_region_e       region;
    logic [PDB_W-1:0]  pdb;
  } skc_db_t;

endpackage

`default_nettype wire

@@ src/skc_log2.sv @@
// Level to log2 converter: saturation, leading-one search, normalisation,
// table lookup with linear interpolation. Five register stages. Uses skc_pkg.
`default_nettype none

module skc_log2
  import skc_pkg::*;
#(
  parameter int LEVEL_WIDTH     = 24,
  parameter int LOG_TABLE_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [LEVEL_WIDTH-1:0] level_i,
  output skc_log_t               log_o
);

  localparam int LF     = LEVEL_WIDTH - 4;
  localparam int P_W    = $clog2(LEVEL_WIDTH);
  localparam int D_W    = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int LOGT_W = 17;
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = LEVEL_WIDTH'(10) << LF;

  function automatic logic [LOG_TABLE_DEPTH:0][LOGT_W-1:0] build_log_tab();
    logic [LOG_TABLE_DEPTH:0][LOGT_W-1:0] tab;
    logic [63:0] y;
    logic [63:0] res;
    tab = '0;
    for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
      if (i == LOG_TABLE_DEPTH) begin
        tab[i] = LOGT_W'(65536);
      end else begin
        y   = ((64'(LOG_TABLE_DEPTH) + 64'(i)) << 30) / LOG_TABLE_DEPTH;
        res = '0;
        for (int k = 1; k <= 20; k++) begin
          y = (y * y) >> 30;
          if (y >= (64'd1 << 31)) begin
            res = res | (64'd1 << (20 - k));
            y   = y >> 1;
          end
        end
        tab[i] = LOGT_W'((res + 64'd8) >> 4);
      end
    end
    return tab;
  endfunction

  localparam logic [LOG_TABLE_DEPTH:0][LOGT_W-1:0] LOG_TAB = build_log_tab();

  // stage 1: saturate, find leading one
  logic [LEVEL_WIDTH-1:0] sat;
  logic [P_W-1:0]         msb;
  logic                   l1_valid_q;
  logic                   l1_zero_q;
  logic [LEVEL_WIDTH-1:0] l1_x_q;
  logic [P_W-1:0]         l1_p_q;

  assign sat = (level_i > LEVEL_MAX) ? LEVEL_MAX : level_i;

  always_comb begin
    msb = '0;
    for (int i = 0; i < LEVEL_WIDTH; i++) begin
      if (sat[i]) begin
        msb = P_W'(i);
      end
    end
  end

  // stage 2: normalise to a 32-bit fraction
  logic [LEVEL_WIDTH+31:0] wide;
  logic                    l2_valid_q;
  logic                    l2_zero_q;
  logic [31:0]             l2_frac_q;
  logic [P_W-1:0]          l2_p_q;

  assign wide = {l1_x_q, 32'b0} >> l1_p_q;

  // stage 3: scale fraction to table index and remainder
  logic [31+D_W:0] t_full;
  logic            l3_valid_q;
  logic            l3_zero_q;
  logic [D_W-1:0]  l3_idx_q;
  logic [15:0]     l3_rem_q;
  logic [P_W-1:0]  l3_p_q;

  assign t_full = l2_frac_q * (32 + D_W)'(LOG_TABLE_DEPTH);

  // stage 4: table read
  logic              l4_valid_q;
  logic              l4_zero_q;
  logic [LOGT_W-1:0] l4_lo_q;
  logic [LOGT_W-1:0] l4_hi_q;
  logic [15:0]       l4_rem_q;
  logic [P_W-1:0]    l4_p_q;

  // stage 5: interpolate, add exponent
  logic [LOGT_W+15:0]       dprod;
  logic [LOGT_W-1:0]        lf;
  logic signed [6:0]        ip;
  logic signed [LOG2_W-1:0] lg_d;
  logic                     l5_valid_q;
  logic                     l5_zero_q;
  logic signed [LOG2_W-1:0] l5_lg_q;

  assign dprod = (l4_hi_q - l4_lo_q) * l4_rem_q;
  assign lf    = l4_lo_q + dprod[LOGT_W+15:16];
  assign ip    = 7'(l4_p_q) - 7'(LF);
  assign lg_d  = LOG2_W'($signed({ip, 16'b0})) + LOG2_W'($signed({1'b0, lf}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_valid_q <= 1'b0;
      l2_valid_q <= 1'b0;
      l3_valid_q <= 1'b0;
      l4_valid_q <= 1'b0;
      l5_valid_q <= 1'b0;
    end else begin
      l1_valid_q <= valid_i;
      l2_valid_q <= l1_valid_q;
      l3_valid_q <= l2_valid_q;
      l4_valid_q <= l3_valid_q;
      l5_valid_q <= l4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l1_zero_q <= (sat == '0);
    l1_x_q    <= sat;
    l1_p_q    <= msb;

    l2_zero_q <= l1_zero_q;
    l2_frac_q <= wide[31:0];
    l2_p_q    <= l1_p_q;

    l3_zero_q <= l2_zero_q;
    l3_idx_q  <= t_full[32 +: D_W];
    l3_rem_q  <= t_full[31:16];
    l3_p_q    <= l2_p_q;

    l4_zero_q <= l3_zero_q;
    l4_lo_q   <= LOG_TAB[l3_idx_q];
    l4_hi_q   <= LOG_TAB[l3_idx_q + D_W'(1)];
    l4_rem_q  <= l3_rem_q;
    l4_p_q    <= l3_p_q;

    l5_zero_q <= l4_zero_q;
    l5_lg_q   <= lg_d;
  end

  assign log_o.valid = l5_valid_q;
  assign log_o.zero  = l5_zero_q;
  assign log_o.lg    = l5_lg_q;

endmodule

`default_nettype wire

@@ src/skc_curve.sv @@
// Static gain curve: level in dB, region decision, compression and knee
// attenuation in dB with clamp. Six register stages. Uses skc_pkg.
`default_nettype none

module skc_curve
  import skc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  skc_cfg_t cfg_i,
  input  skc_log_t log_i,
  output skc_db_t  db_o
);

  localparam int DB_W = 28;  // level dB, signed Q.16
  localparam int CD_W = 23;  // distance above threshold, compression range
  localparam int KU_W = 21;  // offset into the knee
  localparam int SQ_W = 26;
  localparam int PK_W = 34;

  // stage 1: log2 to dB
  logic signed [LOG2_W+19:0] db_prod;
  logic                      c1_valid_q;
  logic                      c1_zero_q;
  logic signed [DB_W-1:0]    c1_ldb_q;

  assign db_prod = (LOG2_W + 20)'($signed(log_i.lg)) * (LOG2_W + 20)'(DB_PER_OCT_Q16);

  // stage 2: distance to threshold
  logic                   c2_valid_q;
  logic                   c2_zero_q;
  logic signed [DB_W-1:0] c2_d_q;

  // stage 3: region
  logic signed [DB_W:0] half_s;
  logic signed [DB_W:0] u_s;
  logic signed [DB_W:0] v_s;
  skc_region_e          region_d;
  logic                 c3_valid_q;
  skc_region_e          c3_region_q;
  logic [CD_W-1:0]      c3_cd_q;
  logic [KU_W-1:0]      c3_ku_q;

  assign half_s = (DB_W + 1)'($signed({1'b0, cfg_i.knee_width, 7'b0}));
  assign u_s    = (DB_W + 1)'(c2_d_q) + half_s;
  assign v_s    = (DB_W + 1)'(c2_d_q) - half_s;

  always_comb begin
    priority if (c2_zero_q || (u_s <= 0)) begin
      region_d = REGION_BELOW;
    end else if (v_s >= 0) begin
      region_d = REGION_COMP;
    end else begin
      region_d = REGION_KNEE;
    end
  end

  // stage 4: slope product and knee square
  logic [SLOPE_W+CD_W-1:0] pc_full;
  logic [2*KU_W-1:0]       sq_full;
  logic                    c4_valid_q;
  skc_region_e             c4_region_q;
  logic [CD_W-1:0]         c4_pc_q;
  logic [SQ_W-1:0]         c4_sq_q;

  assign pc_full = cfg_i.slope * c3_cd_q;
  assign sq_full = c3_ku_q * c3_ku_q;

  // stage 5: knee coefficient product
  logic [COEFF_W+SQ_W-1:0] pk_full;
  logic                    c5_valid_q;
  skc_region_e             c5_region_q;
  logic [CD_W-1:0]         c5_pc_q;
  logic [PK_W-1:0]         c5_pk_q;

  assign pk_full = cfg_i.knee_coeff * c4_sq_q;

  // stage 6: select and clamp at the floor
  logic [PK_W-1:0]  sel;
  logic [PDB_W-1:0] pdb_d;
  logic             c6_valid_q;
  skc_region_e      c6_region_q;
  logic [PDB_W-1:0] c6_pdb_q;

  always_comb begin
    unique case (c5_region_q)
      REGION_COMP: sel = PK_W'(c5_pc_q);
      REGION_KNEE: sel = c5_pk_q;
      default:     sel = '0;
    endcase
    pdb_d = (sel > PK_W'(GDB_FLOOR_Q16)) ? GDB_FLOOR_Q16 : sel[PDB_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_valid_q <= 1'b0;
      c2_valid_q <= 1'b0;
      c3_valid_q <= 1'b0;
      c4_valid_q <= 1'b0;
      c5_valid_q <= 1'b0;
      c6_valid_q <= 1'b0;
    end else begin
      c1_valid_q <= log_i.valid;
      c2_valid_q <= c1_valid_q;
      c3_valid_q <= c2_valid_q;
      c4_valid_q <= c3_valid_q;
      c5_valid_q <= c4_valid_q;
      c6_valid_q <= c5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_zero_q   <= log_i.zero;
    c1_ldb_q    <= DB_W'(db_prod >>> 16);

    c2_zero_q   <= c1_zero_q;
    c2_d_q      <= c1_ldb_q - DB_W'($signed({cfg_i.threshold, 8'b0}));

    c3_region_q <= region_d;
    c3_cd_q     <= CD_W'(c2_d_q);
    c3_ku_q     <= KU_W'(u_s);

    c4_region_q <= c3_region_q;
    c4_pc_q     <= pc_full[SLOPE_W+CD_W-1:16];
    c4_sq_q     <= sq_full[2*KU_W-1:16];

    c5_region_q <= c4_region_q;
    c5_pc_q     <= c4_pc_q;
    c5_pk_q     <= pk_full[COEFF_W+SQ_W-1:16];

    c6_region_q <= c5_region_q;
    c6_pdb_q    <= pdb_d;
  end

  assign db_o.valid  = c6_valid_q;
  assign db_o.region = c6_region_q;
  assign db_o.pdb    = c6_pdb_q;

endmodule

`default_nettype wire

@@ src/skc_exp2.sv @@
// dB to linear gain: scale to octaves, table-based exp2 with interpolation,
// rounding shift and clamp at unity. Five register stages. Uses skc_pkg.
`default_nettype none

module skc_exp2
  import skc_pkg::*;
#(
  parameter int GAIN_WIDTH      = 24,
  parameter int LOG_TABLE_DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  skc_db_t               db_i,
  output logic                  done_o,
  output logic [GAIN_WIDTH-1:0] gain_o,
  output logic [1:0]            region_o
);

  localparam int D_W   = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int E_W   = 24;
  localparam int EP_W  = 48;
  localparam int EXP_W = 34;
  localparam int SH_W  = 6;
  localparam int SH0   = 32 - GAIN_WIDTH;
  localparam logic [GAIN_WIDTH-1:0] UNITY_GAIN = GAIN_WIDTH'(1) << (GAIN_WIDTH - 1);

  function automatic logic [63:0] isqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > v) begin
        b = b >> 2;
      end
    end
    for (int k = 0; k < 32; k++) begin
      if (b != '0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [LOG_TABLE_DEPTH:0][EXP_W-1:0] build_exp_tab();
    logic [LOG_TABLE_DEPTH:0][EXP_W-1:0] tab;
    logic [63:0] roots [0:30];
    logic [63:0] f32;
    logic [63:0] p;
    tab      = '0;
    roots[0] = 64'd2 << 30;
    for (int k = 1; k <= 30; k++) begin
      roots[k] = isqrt(roots[k-1] << 30);
    end
    for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
      if (i == LOG_TABLE_DEPTH) begin
        tab[i] = EXP_W'(64'd1 << 33);
      end else begin
        f32 = (64'(i) << 32) / LOG_TABLE_DEPTH;
        p   = 64'd1 << 30;
        for (int k = 1; k <= 30; k++) begin
          if (f32[32-k]) begin
            p = (p * roots[k]) >> 30;
          end
        end
        tab[i] = EXP_W'(p << 2);
      end
    end
    return tab;
  endfunction

  localparam logic [LOG_TABLE_DEPTH:0][EXP_W-1:0] EXP_TAB = build_exp_tab();

  // stage 1: dB to octaves
  logic signed [PDB_W+1:0] neg;
  logic signed [EP_W-1:0]  ep;
  logic                    e1_valid_q;
  skc_region_e             e1_region_q;
  logic signed [E_W-1:0]   e1_e_q;

  assign neg = -$signed({2'b0, db_i.pdb});
  assign ep  = EP_W'(neg) * EP_W'(OCT_PER_DB_Q24);

  // stage 2: split integer and fraction, index and shift
  logic signed [7:0] ip;
  logic [7:0]        sh;
  logic [15+D_W:0]   t_full;
  logic              e2_valid_q;
  skc_region_e       e2_region_q;
  logic [D_W-1:0]    e2_idx_q;
  logic [15:0]       e2_rem_q;
  logic [SH_W-1:0]   e2_sh_q;

  assign ip     = $signed(e1_e_q[E_W-1:16]);
  assign sh     = 8'(SH0) - ip;
  assign t_full = e1_e_q[15:0] * (16 + D_W)'(LOG_TABLE_DEPTH);

  // stage 3: table read
  logic             e3_valid_q;
  skc_region_e      e3_region_q;
  logic [EXP_W-1:0] e3_lo_q;
  logic [EXP_W-1:0] e3_hi_q;
  logic [15:0]      e3_rem_q;
  logic [SH_W-1:0]  e3_sh_q;

  // stage 4: interpolate
  logic [EXP_W+15:0] dprod;
  logic              e4_valid_q;
  skc_region_e       e4_region_q;
  logic [EXP_W-1:0]  e4_m_q;
  logic [SH_W-1:0]   e4_sh_q;

  assign dprod = (e3_hi_q - e3_lo_q) * e3_rem_q;

  // stage 5: round half up to gain width, clamp at unity
  logic [EXP_W-1:0]      r;
  logic [EXP_W:0]        rnd;
  logic [EXP_W-1:0]      g;
  logic [GAIN_WIDTH-1:0] gain_d;
  logic                  e5_valid_q;
  skc_region_e           e5_region_q;
  logic [GAIN_WIDTH-1:0] e5_gain_q;

  assign r      = e4_m_q >> e4_sh_q;
  assign rnd    = {1'b0, r} + (EXP_W + 1)'(1);
  assign g      = rnd[EXP_W:1];
  assign gain_d = (g > EXP_W'(UNITY_GAIN)) ? UNITY_GAIN : g[GAIN_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
      e2_valid_q <= 1'b0;
      e3_valid_q <= 1'b0;
      e4_valid_q <= 1'b0;
      e5_valid_q <= 1'b0;
    end else begin
      e1_valid_q <= db_i.valid;
      e2_valid_q <= e1_valid_q;
      e3_valid_q <= e2_valid_q;
      e4_valid_q <= e3_valid_q;
      e5_valid_q <= e4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_region_q <= db_i.region;
    e1_e_q      <= E_W'(ep >>> 24);

    e2_region_q <= e1_region_q;
    e2_idx_q    <= t_full[16 +: D_W];
    e2_rem_q    <= t_full[15:0];
    e2_sh_q     <= sh[SH_W-1:0];

    e3_region_q <= e2_region_q;
    e3_lo_q     <= EXP_TAB[e2_idx_q];
    e3_hi_q     <= EXP_TAB[e2_idx_q + D_W'(1)];
    e3_rem_q    <= e2_rem_q;
    e3_sh_q     <= e2_sh_q;

    e4_region_q <= e3_region_q;
    e4_m_q      <= e3_lo_q + dprod[EXP_W+15:16];
    e4_sh_q     <= e3_sh_q;

    e5_region_q <= e4_region_q;
    e5_gain_q   <= gain_d;
  end

  assign done_o   = e5_valid_q;
  assign gain_o   = e5_gain_q;
  assign region_o = e5_region_q;

endmodule

`default_nettype wire

@@ src/soft_knee_compressor_gain_top.sv @@
// Top level of the soft-knee compressor gain computer: configuration
// registers and the log2, curve and exp2 pipelines. Uses skc_pkg.
//
// One level word is taken in every clock cycle; busy_o is never raised.
// Each word gives one result, with done_o high for exactly one cycle when
// the word has passed through every register stage and leaves the last exp2 stage.
// There are 16 register stages in all, the first loaded at the edge that
// takes the level: five of log2 (saturate and leading-one search, normalise,
// index, table read, interpolate), six of gain curve (dB scale, threshold,
// region, two multiplier stages, clamp) and five of exp2. Results leave in
// input order and cannot be held off. The log2 and exp2 tables are constant
// logic. Configuration is taken at any time on the cfg channel but should
// only be written with no word in flight.
`default_nettype none

module soft_knee_compressor_gain_top
  import skc_pkg::*;
#(
  parameter int LEVEL_WIDTH     = 24,
  parameter int GAIN_WIDTH      = 24,
  parameter int LOG_TABLE_DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [LEVEL_WIDTH-1:0] level_i,
  output logic                  done_o,
  output logic [GAIN_WIDTH-1:0] gain_o,
  output logic [1:0]            region_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  skc_cfg_t cfg_d;
  skc_cfg_t cfg_q;
  skc_log_t log_w;
  skc_db_t  db_w;
  logic     in_valid;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_valid    = start_i & ~busy_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (skc_cfg_idx_e'(cfg_index_i))
        CFG_THRESHOLD:  cfg_d.threshold  = $signed(cfg_data_i[THR_W-1:0]);
        CFG_SLOPE:      cfg_d.slope      = cfg_data_i[SLOPE_W-1:0];
        CFG_KNEE_WIDTH: cfg_d.knee_width = cfg_data_i[KNEE_W-1:0];
        CFG_KNEE_COEFF: cfg_d.knee_coeff = cfg_data_i[COEFF_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= THRESHOLD_RST;
      cfg_q.slope      <= SLOPE_RST;
      cfg_q.knee_width <= KNEE_WIDTH_RST;
      cfg_q.knee_coeff <= KNEE_COEFF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  skc_log2 #(
    .LEVEL_WIDTH     (LEVEL_WIDTH),
    .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .level_i (level_i),
    .log_o   (log_w)
  );

  skc_curve u_curve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .log_i  (log_w),
    .db_o   (db_w)
  );

  skc_exp2 #(
    .GAIN_WIDTH      (GAIN_WIDTH),
    .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
  ) u_exp2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .db_i     (db_w),
    .done_o   (done_o),
    .gain_o   (gain_o),
    .region_o (region_o)
  );

endmodule

`default_nettype wire

@@ tb/skc_gain_checker.sv @@
`timescale 1ns / 100ps
// Gain checker for the soft-knee compressor gain computer: watches the level,
// result and register channels, predicts each gain word and compares it.
// Depends on skc_pkg for the register layout, region and register codes.

module skc_gain_checker
  import skc_pkg::*;
#(
  parameter int LEVEL_WIDTH     = 24,
  parameter int GAIN_WIDTH      = 24,
  parameter int LOG_TABLE_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic [LEVEL_WIDTH-1:0] level_i,
  input  logic                   done_i,
  input  logic [GAIN_WIDTH-1:0]  gain_i,
  input  logic [1:0]             region_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     pending_o,
  output int                     fail_count_o
);

  localparam longint          DB_PER_OCTAVE = 394566;
  localparam longint          OCTAVE_PER_DB = 2786618;
  localparam longint          ATTEN_FLOOR   = 13107200;
  localparam int              LEVEL_FRAC    = LEVEL_WIDTH - 4;
  localparam longint unsigned DEPTH         = LOG_TABLE_DEPTH;
  localparam longint unsigned LEVEL_MAX     = 64'd10 << LEVEL_FRAC;
  localparam longint unsigned UNITY_GAIN    = 64'd1 << (GAIN_WIDTH - 1);

  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] level;
    logic [GAIN_WIDTH-1:0]  gain;
    skc_region_e            region;
  } gain_word_t;

  longint unsigned log_lut [0:LOG_TABLE_DEPTH];
  longint unsigned exp_lut [0:LOG_TABLE_DEPTH];
  skc_cfg_t        shadow_cfg;
  gain_word_t      expected_gain_q [$];
  gain_word_t      oldest;
  int              mismatches = 0;

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1+i/D) in Q0.16 and 2^(i/D) in Q2.32, bit-exact integer construction
  function automatic void build_curve_tables();
    longint unsigned roots [0:30];
    longint unsigned y, res, f32, p, i;
    int              k;
    roots[0] = 64'd2 << 30;
    for (k = 1; k <= 30; k++) roots[k] = isqrt64(roots[k-1] << 30);
    for (i = 0; i <= DEPTH; i++) begin
      if (i == DEPTH) begin
        log_lut[i] = 64'd1 << 16;
        exp_lut[i] = 64'd1 << 33;
      end else begin
        y   = ((DEPTH + i) << 30) / DEPTH;
        res = 0;
        for (k = 1; k <= 20; k++) begin
          y = (y * y) >> 30;
          if (y >= (64'd1 << 31)) begin
            res = res | (64'd1 << (20 - k));
            y   = y >> 1;
          end
        end
        log_lut[i] = (res + 8) >> 4;
        f32 = (i << 32) / DEPTH;
        p   = 64'd1 << 30;
        for (k = 1; k <= 30; k++)
          if (f32[32-k]) p = (p * roots[k]) >> 30;
        exp_lut[i] = p << 2;
      end
    end
  endfunction

  function automatic longint level_to_log2(longint unsigned x);
    int              p;
    longint unsigned frac32, t, idx, rem, lf;
    p = 63;
    while (p > 0 && !x[p]) p--;
    frac32 = (x - (64'd1 << p)) << (32 - p);
    t      = frac32 * DEPTH;
    idx    = t >> 32;
    rem    = (t >> 16) & 64'hFFFF;
    lf     = log_lut[idx] + (((log_lut[idx+1] - log_lut[idx]) * rem) >> 16);
    return longint'(p - LEVEL_FRAC) * 65536 + longint'(lf);
  endfunction

  function automatic longint unsigned atten_to_gain(longint gdb);
    longint          e, ip, f, sh;
    longint unsigned t, idx, rem, m, g;
    if (gdb < -ATTEN_FLOOR) gdb = -ATTEN_FLOOR;
    if (gdb > 0) gdb = 0;
    e   = (gdb * OCTAVE_PER_DB) >>> 24;
    ip  = e >>> 16;
    f   = e - ip * 65536;
    t   = unsigned'(f) * DEPTH;
    idx = t >> 16;
    rem = t & 64'hFFFF;
    m   = exp_lut[idx] + (((exp_lut[idx+1] - exp_lut[idx]) * rem) >> 16);
    sh  = 33 - GAIN_WIDTH - ip;
    if (sh >= 63) return 0;
    g = (m + (64'd1 << (sh - 1))) >> sh;
    if (g > UNITY_GAIN) g = UNITY_GAIN;
    return g;
  endfunction

  function automatic gain_word_t predict_gain(logic [LEVEL_WIDTH-1:0] level);
    longint unsigned lvl, u, sq, prod, g;
    longint          ldb, d, half;
    gain_word_t      w;
    lvl      = level;
    g        = UNITY_GAIN;
    w.level  = level;
    w.region = REGION_BELOW;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    if (lvl != 0) begin
      ldb  = (level_to_log2(lvl) * DB_PER_OCTAVE) >>> 16;
      d    = ldb - longint'(shadow_cfg.threshold) * 256;
      half = longint'(shadow_cfg.knee_width) * 128;
      if (d <= -half) begin
        w.region = REGION_BELOW;
      end else if (d >= half) begin
        prod     = (64'(shadow_cfg.slope) * unsigned'(d)) >> 16;
        w.region = REGION_COMP;
        g        = atten_to_gain(-longint'(prod));
      end else begin
        u        = unsigned'(d + half);
        sq       = (u * u) >> 16;
        prod     = (64'(shadow_cfg.knee_coeff) * sq) >> 16;
        w.region = REGION_KNEE;
        g        = atten_to_gain(-longint'(prod));
      end
    end
    w.gain = g[GAIN_WIDTH-1:0];
    return w;
  endfunction

  initial build_curve_tables();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_gain_q.delete();
      shadow_cfg.threshold  = 14'sd0;
      shadow_cfg.slope      = 16'd32768;
      shadow_cfg.knee_width = 13'd1536;
      shadow_cfg.knee_coeff = 24'd1365;
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (done_i) begin
        if (expected_gain_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word gain %h region %0d",
                     $realtime, gain_i, region_i);
        end else begin
          oldest = expected_gain_q.pop_front();
          if (gain_i !== oldest.gain || region_i !== oldest.region) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: level %h: expected gain %h region %0d, got gain %h region %0d",
                       $realtime, oldest.level, oldest.gain, oldest.region,
                       gain_i, region_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD:  shadow_cfg.threshold  = cfg_data_i[THR_W-1:0];
          CFG_SLOPE:      shadow_cfg.slope      = cfg_data_i[SLOPE_W-1:0];
          CFG_KNEE_WIDTH: shadow_cfg.knee_width = cfg_data_i[KNEE_W-1:0];
          CFG_KNEE_COEFF: shadow_cfg.knee_coeff = cfg_data_i[COEFF_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) expected_gain_q.push_back(predict_gain(level_i));
      pending_o    <= expected_gain_q.size();
      fail_count_o <= mismatches + expected_gain_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the compressor gain testbench: clock, reset, level and register
// stimulus, and the verdict. Depends on skc_pkg, skc_gain_checker and the block.

module testbench;
  import skc_pkg::*;

  localparam int LEVEL_WIDTH = 24;
  localparam int GAIN_WIDTH  = 24;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [LEVEL_WIDTH-1:0] level_i;
  logic                   done_o;
  logic [GAIN_WIDTH-1:0]  gain_o;
  logic [1:0]             region_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  int                     pending;
  int                     fail_count;

  soft_knee_compressor_gain_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .level_i     (level_i),
    .done_o      (done_o),
    .gain_o      (gain_o),
    .region_o    (region_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  skc_gain_checker gain_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .level_i      (level_i),
    .done_i       (done_o),
    .gain_i       (gain_o),
    .region_i     (region_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input skc_cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] thr, slope, knee, coeff);
    wait_idle();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_SLOPE, slope);
    write_reg(CFG_KNEE_WIDTH, knee);
    write_reg(CFG_KNEE_COEFF, coeff);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_level(input logic [LEVEL_WIDTH-1:0] lvl, input bit may_idle);
    if (may_idle && $urandom_range(99) < 19) begin
      start_i <= 1'b0;
      level_i <= LEVEL_WIDTH'($urandom);
      repeat (($urandom_range(9) == 0) ? $urandom_range(2, 5) : 1) @(posedge clk_i);
    end
    start_i <= 1'b1;
    level_i <= lvl;
    do @(posedge clk_i); while (busy_o);
  endtask

  // mostly log-uniform over the useful dB range, plus zero, raw and saturating words
  function automatic logic [LEVEL_WIDTH-1:0] random_level();
    int unsigned sel, e;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 20) return LEVEL_WIDTH'($urandom);
    if (sel < 25) return LEVEL_WIDTH'($urandom_range(10485700, 10485800));
    e = (sel < 40) ? $urandom_range(0, 23) : $urandom_range(14, 23);
    return (24'd1 << e) | (24'($urandom) & ((24'd1 << e) - 24'd1));
  endfunction

  initial begin : stimulus
    int unsigned     ph, n, slp, kw;
    int              thr;
    longint unsigned kc;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    level_i     <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_THRESHOLD;
    cfg_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero, tiny, saturating and alternating-bit levels
    send_level(24'd0, 1'b0);
    send_level(24'd1, 1'b0);
    send_level(24'd2, 1'b0);
    send_level(24'h000FFF, 1'b0);
    send_level(24'h100000, 1'b0);
    send_level(24'h0B504F, 1'b0);
    send_level(24'h16A09E, 1'b0);
    send_level(24'hA00000, 1'b0);
    send_level(24'hA00001, 1'b0);
    send_level(24'hFFFFFF, 1'b0);
    send_level(24'h800000, 1'b0);
    send_level(24'h555555, 1'b0);
    send_level(24'hAAAAAA, 1'b0);
    // unity level sits exactly on the lower, then the upper knee edge
    apply_settings(24'd768, 24'd32768, 24'd1536, 24'd1365);
    send_level(24'h100000, 1'b0);
    apply_settings(-24'd768, 24'd32768, 24'd1536, 24'd1365);
    send_level(24'h100000, 1'b0);
    // hard knee
    apply_settings(24'd0, 24'd32768, 24'd0, 24'd1365);
    send_level(24'h100000, 1'b0);
    send_level(24'h104000, 1'b0);
    // attenuation deep enough to underflow
    apply_settings(24'd0, 24'd65535, 24'd8191, 24'hFFFFFF);
    send_level(24'h100000, 1'b0);
    send_level(24'hA00000, 1'b0);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_settings(24'd0, 24'd32768, 24'd1536, 24'd1365);
        1: apply_settings(-24'd7680, 24'd58982, 24'd4608, 24'hFFFFFF);
        2: apply_settings(24'd1536, 24'd0, 24'd0, 24'd0);
        3, 5: begin
          thr = int'($urandom_range(9216)) - 7680;
          slp = $urandom_range(58982);
          kw  = $urandom_range(4608);
          kc  = (kw == 0) ? 64'hFFFFFF : (64'(slp) * 64) / kw;
          if (kc > 64'hFFFFFF) kc = 64'hFFFFFF;
          apply_settings(24'(thr), 24'(slp), 24'(kw), 24'(kc));
        end
        default: apply_settings(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
      endcase
      if (ph == 4) begin
        // register width extremes, out of the stated ranges
        apply_settings(24'h002000, 24'h00FFFF, 24'h001FFF, 24'hFFFFFF);
      end
      for (n = 0; n < 258; n++) begin
        if (ph == 3 && n == 130) wait_idle();
        send_level(random_level(), ph != 2);
      end
    end

    wait_idle();
    repeat (24) @(posedge clk_i);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
